// File: hw/rtl/x25rx_pkg.sv
package x25rx_pkg;

  localparam int unsigned SEQ_W      = 7;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SEQ_W-1:0] EXT_SEQ_MASK = 7'h7F;
  localparam logic [SEQ_W-1:0] STD_SEQ_MASK = 7'h07;

  localparam logic [CFG_IDX_W-1:0] CFG_EXT_NUMBERING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_HOLDBACK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_WAIT    = 2'd3;

  localparam logic [3:0] ACT_CALL_ACCEPTED = 4'd0;
  localparam logic [3:0] ACT_CLEAR_REQ     = 4'd1;
  localparam logic [3:0] ACT_CLEAR_CONF    = 4'd2;
  localparam logic [3:0] ACT_RESET_REQ     = 4'd3;
  localparam logic [3:0] ACT_RESET_CONF    = 4'd4;
  localparam logic [3:0] ACT_RR            = 4'd5;
  localparam logic [3:0] ACT_RNR           = 4'd6;
  localparam logic [3:0] ACT_DATA          = 4'd7;
  localparam logic [3:0] ACT_INTERRUPT     = 4'd8;
  localparam logic [3:0] ACT_INT_CONF      = 4'd9;
  localparam logic [3:0] ACT_LOCAL_CALL    = 4'd11;
  localparam logic [3:0] ACT_LOCAL_CLEAR   = 4'd12;
  localparam logic [3:0] ACT_LOCAL_SENT    = 4'd13;
  localparam logic [3:0] ACT_LOCAL_RX_RDY  = 4'd14;

  localparam logic [2:0] PH_READY         = 3'd0;
  localparam logic [2:0] PH_AWAIT_ACCEPT  = 3'd1;
  localparam logic [2:0] PH_AWAIT_CLEAR   = 3'd2;
  localparam logic [2:0] PH_DATA_TRANSFER = 3'd3;
  localparam logic [2:0] PH_AWAIT_RESET   = 3'd4;

  localparam logic [2:0] PKT_NONE       = 3'd0;
  localparam logic [2:0] PKT_RESET_CONF = 3'd1;
  localparam logic [2:0] PKT_CLEAR_CONF = 3'd2;
  localparam logic [2:0] PKT_RESET_REQ  = 3'd3;
  localparam logic [2:0] PKT_RR         = 3'd4;
  localparam logic [2:0] PKT_RNR        = 3'd5;
  localparam logic [2:0] PKT_INT_CONF   = 3'd6;

  localparam logic [1:0] CLOSE_NONE    = 2'd0;
  localparam logic [1:0] CLOSE_REFUSED = 2'd1;
  localparam logic [1:0] CLOSE_NORMAL  = 2'd2;

  typedef struct packed {
    logic               extended_numbering;
    logic [SEQ_W-1:0]   receive_window;
    logic [TIMER_W-1:0] ack_holdback_ticks;
    logic [TIMER_W-1:0] reset_wait_ticks;
  } x25rx_cfg_t;

  typedef struct packed {
    logic [2:0]         call_phase;
    logic [SEQ_W-1:0]   next_send;
    logic [SEQ_W-1:0]   next_recv;
    logic [SEQ_W-1:0]   peer_acked;
    logic [SEQ_W-1:0]   last_acked_recv;
    logic               peer_busy;
    logic               own_busy;
    logic               ack_pending;
    logic               interrupt_outstanding;
    logic [TIMER_W-1:0] timer_value;
    logic               call_closed;
  } x25rx_state_t;

  typedef struct packed {
    logic [3:0]       action;
    logic [SEQ_W-1:0] send_seq;
    logic [SEQ_W-1:0] ack_seq_in;
    logic             more_data;
    logic             sink_ready;
  } x25rx_item_t;

  typedef struct packed {
    logic [2:0]         call_state;
    logic [2:0]         send_packet;
    logic               deliver;
    logic               last_fragment;
    logic               urgent_notice;
    logic [TIMER_W-1:0] timer_load;
    logic [1:0]         close_reason;
    logic               state_changed;
    logic [SEQ_W-1:0]   recv_seq_out;
    logic [SEQ_W-1:0]   acked_seq_out;
  } x25rx_res_t;

endpackage

// File: hw/rtl/x25rx_ifs.sv
interface x25rx_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [6:0] send_seq;
  logic [6:0] ack_seq_in;
  logic       more_data;
  logic       sink_ready;

  modport source (output valid, action, send_seq, ack_seq_in, more_data, sink_ready,
                  input ready);
  modport sink (input valid, action, send_seq, ack_seq_in, more_data, sink_ready,
                output ready);
endinterface

interface x25rx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  call_state;
  logic [2:0]  send_packet;
  logic        deliver;
  logic        last_fragment;
  logic        urgent_notice;
  logic [15:0] timer_load;
  logic [1:0]  close_reason;
  logic        state_changed;
  logic [6:0]  recv_seq_out;
  logic [6:0]  acked_seq_out;

  modport source (output valid, call_state, send_packet, deliver, last_fragment,
                  urgent_notice, timer_load, close_reason, state_changed,
                  recv_seq_out, acked_seq_out,
                  input ready);
  modport sink (input valid, call_state, send_packet, deliver, last_fragment,
                urgent_notice, timer_load, close_reason, state_changed,
                recv_seq_out, acked_seq_out,
                output ready);
endinterface

// File: hw/rtl/x25rx_step.sv
module x25rx_step
  import x25rx_pkg::*;
(
  input  x25rx_cfg_t   cfg,
  input  x25rx_state_t st,
  input  x25rx_item_t  item,
  output x25rx_state_t st_nxt,
  output x25rx_res_t   res
);

  logic [SEQ_W-1:0] mask;
  logic [SEQ_W-1:0] ns;
  logic [SEQ_W-1:0] nr;
  logic [SEQ_W-1:0] nr_span;
  logic [SEQ_W-1:0] vs_span;
  logic [SEQ_W-1:0] win_edge;
  logic [SEQ_W-1:0] sent_span;

  x25rx_state_t s;

  always_comb begin
    mask = cfg.extended_numbering ? EXT_SEQ_MASK : STD_SEQ_MASK;
    ns   = item.send_seq & mask;
    nr   = item.ack_seq_in & mask;

    s = st;
    s.next_send       = st.next_send & mask;
    s.next_recv       = st.next_recv & mask;
    s.peer_acked      = st.peer_acked & mask;
    s.last_acked_recv = st.last_acked_recv & mask;

    nr_span   = (nr - s.peer_acked) & mask;
    vs_span   = (s.next_send - s.peer_acked) & mask;
    sent_span = (s.next_send + 7'd1 - s.peer_acked) & mask;
    win_edge  = '0;

    res               = '0;
    res.send_packet   = PKT_NONE;
    res.close_reason  = CLOSE_NONE;

    case (s.call_phase)
      PH_READY: begin
        if (item.action == ACT_LOCAL_CALL) begin
          s.peer_busy             = 1'b0;
          s.own_busy              = 1'b0;
          s.ack_pending           = 1'b0;
          s.next_send             = '0;
          s.next_recv             = '0;
          s.peer_acked            = '0;
          s.last_acked_recv       = '0;
          s.interrupt_outstanding = 1'b0;
          s.timer_value           = '0;
          s.call_closed           = 1'b0;
          s.call_phase            = PH_AWAIT_ACCEPT;
        end
      end
      PH_AWAIT_ACCEPT: begin
        if (item.action == ACT_CALL_ACCEPTED) begin
          s.peer_busy       = 1'b0;
          s.own_busy        = 1'b0;
          s.ack_pending     = 1'b0;
          s.next_send       = '0;
          s.next_recv       = '0;
          s.peer_acked      = '0;
          s.last_acked_recv = '0;
          s.timer_value     = '0;
          s.call_phase      = PH_DATA_TRANSFER;
          res.state_changed = !st.call_closed;
        end else if (item.action == ACT_CLEAR_REQ) begin
          s.call_phase      = PH_READY;
          res.close_reason  = CLOSE_REFUSED;
          res.state_changed = !st.call_closed;
          s.call_closed     = 1'b1;
        end else if (item.action == ACT_LOCAL_CLEAR) begin
          s.timer_value = '0;
          s.call_phase  = PH_AWAIT_CLEAR;
        end
      end
      PH_AWAIT_CLEAR: begin
        if (item.action inside {ACT_CLEAR_REQ, ACT_CLEAR_CONF}) begin
          s.call_phase      = PH_READY;
          res.close_reason  = CLOSE_NORMAL;
          res.state_changed = !st.call_closed;
          s.call_closed     = 1'b1;
        end
      end
      PH_DATA_TRANSFER: begin
        if (item.action == ACT_RESET_REQ) begin
          res.send_packet   = PKT_RESET_CONF;
          s.peer_busy       = 1'b0;
          s.own_busy        = 1'b0;
          s.ack_pending     = 1'b0;
          s.next_send       = '0;
          s.next_recv       = '0;
          s.peer_acked      = '0;
          s.last_acked_recv = '0;
          s.timer_value     = '0;
        end else if (item.action == ACT_CLEAR_REQ) begin
          res.send_packet   = PKT_CLEAR_CONF;
          s.call_phase      = PH_READY;
          res.close_reason  = CLOSE_NORMAL;
          res.state_changed = !st.call_closed;
          s.call_closed     = 1'b1;
        end else if (item.action inside {ACT_RR, ACT_RNR, ACT_DATA}) begin
          s.peer_busy = (item.action == ACT_RNR);
          if (nr_span > vs_span) begin
            res.send_packet   = PKT_RESET_REQ;
            s.peer_busy       = 1'b0;
            s.own_busy        = 1'b0;
            s.ack_pending     = 1'b0;
            s.next_send       = '0;
            s.next_recv       = '0;
            s.peer_acked      = '0;
            s.last_acked_recv = '0;
            s.call_phase      = PH_AWAIT_RESET;
            s.timer_value     = cfg.reset_wait_ticks;
          end else begin
            s.peer_acked = nr;
            if (item.action == ACT_DATA && !s.own_busy) begin
              if (ns == s.next_recv) begin
                if (item.sink_ready) begin
                  s.next_recv       = (s.next_recv + 7'd1) & mask;
                  res.deliver       = 1'b1;
                  res.last_fragment = !item.more_data;
                end else begin
                  s.own_busy = 1'b1;
                end
              end
              win_edge = (s.last_acked_recv + cfg.receive_window) & mask;
              if (win_edge == s.next_recv) begin
                s.ack_pending     = 1'b0;
                s.timer_value     = '0;
                res.send_packet   = s.own_busy ? PKT_RNR : PKT_RR;
                s.last_acked_recv = s.next_recv;
              end else begin
                s.ack_pending = 1'b1;
                s.timer_value = cfg.ack_holdback_ticks;
              end
            end
          end
        end else if (item.action == ACT_INT_CONF) begin
          s.interrupt_outstanding = 1'b0;
        end else if (item.action == ACT_INTERRUPT) begin
          res.urgent_notice = 1'b1;
          res.send_packet   = PKT_INT_CONF;
        end else if (item.action == ACT_LOCAL_CLEAR) begin
          s.timer_value = '0;
          s.call_phase  = PH_AWAIT_CLEAR;
        end else if (item.action == ACT_LOCAL_SENT) begin
          if (sent_span != '0) begin
            s.next_send = (s.next_send + 7'd1) & mask;
          end
        end else if (item.action == ACT_LOCAL_RX_RDY) begin
          if (s.own_busy) begin
            s.own_busy        = 1'b0;
            s.ack_pending     = 1'b0;
            res.send_packet   = PKT_RR;
            s.last_acked_recv = s.next_recv;
            s.timer_value     = '0;
          end
        end
      end
      PH_AWAIT_RESET: begin
        if (item.action inside {ACT_RESET_REQ, ACT_RESET_CONF}) begin
          s.timer_value     = '0;
          s.peer_busy       = 1'b0;
          s.own_busy        = 1'b0;
          s.ack_pending     = 1'b0;
          s.next_send       = '0;
          s.next_recv       = '0;
          s.peer_acked      = '0;
          s.last_acked_recv = '0;
          s.call_phase      = PH_DATA_TRANSFER;
        end else if (item.action == ACT_CLEAR_REQ) begin
          res.send_packet   = PKT_CLEAR_CONF;
          s.timer_value     = '0;
          s.call_phase      = PH_READY;
          res.close_reason  = CLOSE_NORMAL;
          res.state_changed = !st.call_closed;
          s.call_closed     = 1'b1;
        end else if (item.action == ACT_LOCAL_CLEAR) begin
          s.timer_value = '0;
          s.call_phase  = PH_AWAIT_CLEAR;
        end
      end
      default: begin
      end
    endcase

    st_nxt            = s;
    res.call_state    = s.call_phase;
    res.timer_load    = s.timer_value;
    res.recv_seq_out  = s.next_recv;
    res.acked_seq_out = s.peer_acked;
  end

endmodule

// File: hw/rtl/x25_packet_layer_rx_fsm.sv
// Channel   Dir  Handshake          Content
// in_ch     in   valid/ready        one decoded packet or local action per word
// out_ch    out  valid/ready        one result word per input word
// cfg_*     in   cfg_we, no ready   register index and write data
//
// Each word passes an input register and a result register; its result is registered
// when it advances. One word per cycle is sustained while out_ch is ready, limited only
// by the single step of the call state update between the two registers.
// Reset is synchronous on rst_n and restores the call state and register defaults.
// A stalled out_ch holds its result while one more input word waits in the input register.
module x25_packet_layer_rx_fsm
  import x25rx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  x25rx_in_if.sink              in_ch,
  x25rx_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  x25rx_cfg_t   cfg_r;
  x25rx_state_t st_r;
  x25rx_state_t st_nxt;
  x25rx_item_t  item_r;
  x25rx_item_t  item_nxt;
  x25rx_res_t   res_r;
  x25rx_res_t   res_nxt;
  logic         in_valid_r;
  logic         out_valid_r;
  logic         advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  assign item_nxt.action     = in_ch.action;
  assign item_nxt.send_seq   = in_ch.send_seq;
  assign item_nxt.ack_seq_in = in_ch.ack_seq_in;
  assign item_nxt.more_data  = in_ch.more_data;
  assign item_nxt.sink_ready = in_ch.sink_ready;

  x25rx_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.extended_numbering <= 1'b0;
      cfg_r.receive_window     <= 7'd2;
      cfg_r.ack_holdback_ticks <= 16'd300;
      cfg_r.reset_wait_ticks   <= 16'd18000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXT_NUMBERING: cfg_r.extended_numbering <= cfg_wdata[0];
        CFG_RECV_WINDOW:   cfg_r.receive_window     <= cfg_wdata[SEQ_W-1:0];
        CFG_ACK_HOLDBACK:  cfg_r.ack_holdback_ticks <= cfg_wdata[TIMER_W-1:0];
        CFG_RESET_WAIT:    cfg_r.reset_wait_ticks   <= cfg_wdata[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.call_state    = res_r.call_state;
  assign out_ch.send_packet   = res_r.send_packet;
  assign out_ch.deliver       = res_r.deliver;
  assign out_ch.last_fragment = res_r.last_fragment;
  assign out_ch.urgent_notice = res_r.urgent_notice;
  assign out_ch.timer_load    = res_r.timer_load;
  assign out_ch.close_reason  = res_r.close_reason;
  assign out_ch.state_changed = res_r.state_changed;
  assign out_ch.recv_seq_out  = res_r.recv_seq_out;
  assign out_ch.acked_seq_out = res_r.acked_seq_out;

  a_res_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.call_state == st_r.call_phase &&
                     res_r.recv_seq_out == st_r.next_recv &&
                     res_r.acked_seq_out == st_r.peer_acked))
    else $error("result word does not match the call state");

  a_deliver_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.deliver) |-> res_r.call_state == PH_DATA_TRANSFER)
    else $error("data delivered outside data transfer");

  a_last_needs_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.last_fragment) |-> res_r.deliver)
    else $error("last fragment flagged without delivery");

  a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("pending word did not reach the result register");

endmodule
